// ===== rtl/fm_stereo_pilot_pll_defines.svh =====
// assertion macros shared by the pilot pll rtl
`ifndef FM_STEREO_PILOT_PLL_DEFINES_SVH
`define FM_STEREO_PILOT_PLL_DEFINES_SVH

// same-cycle implication, checked out of reset
`define FSP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fsp assertion failed");

// next-cycle implication, checked out of reset
`define FSP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fsp assertion failed");

`endif

// ===== rtl/fsp_pkg.sv =====
// types, constants and fixed-point helpers for the pilot pll
package fsp_pkg;

  localparam int RENORM_PERIOD_DEF = 512;
  localparam int PHASE_CYCLES_DEF  = 16;

  localparam int MUL_W  = 36;
  localparam int WIDE_W = 2 * MUL_W;

  typedef logic signed [MUL_W-1:0]  mop_t;
  typedef logic signed [WIDE_W-1:0] wide_t;

  // register indexes
  localparam logic [3:0] REG_PHASE_STEP   = 4'd0;
  localparam logic [3:0] REG_NOM_ROT      = 4'd1;
  localparam logic [3:0] REG_GAIN_PROP    = 4'd2;
  localparam logic [3:0] REG_GAIN_INT     = 4'd3;
  localparam logic [3:0] REG_LOCK_SMOOTH  = 4'd4;
  localparam logic [3:0] REG_RELEASE_HOLD = 4'd5;
  localparam logic [3:0] REG_LOCK_THR     = 4'd6;
  localparam logic [3:0] REG_TRACK_THR    = 4'd7;

  localparam logic [31:0] PHASE_STEP_RST   = 32'd340010602;
  localparam logic [31:0] NOM_ROT_RST      = 32'd2147418112;
  localparam logic [23:0] GAIN_PROP_RST    = 24'd117440;
  localparam logic [23:0] GAIN_INT_RST     = 24'd107374;
  localparam logic [23:0] LOCK_SMOOTH_RST  = 24'd162688;
  localparam logic [23:0] RELEASE_HOLD_RST = 24'd240000;

  localparam wide_t ONE_Q30      = 72'sd1073741824;
  localparam wide_t ONE_HALF_Q30 = 72'sd1610612736;
  localparam wide_t THREE_Q30    = 72'sd3221225472;
  localparam mop_t  INV_PI_Q32   = 36'sd1367130551;

  // round half up then floor shift
  function automatic wide_t rnd(input wide_t v, input int unsigned n);
    wide_t h;
    h = wide_t'(1) <<< (n - 1);
    return (v + h) >>> n;
  endfunction

  function automatic logic signed [31:0] sat32(input wide_t v);
    logic signed [31:0] r;
    if (v > wide_t'(32'sh7fffffff)) r = 32'sh7fffffff;
    else if (v < -wide_t'(64'sh80000000)) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [15:0] sat16(input wide_t v);
    logic signed [15:0] r;
    if (v > wide_t'(16'sh7fff)) r = 16'sh7fff;
    else if (v < -wide_t'(32'sh8000)) r = 16'sh8000;
    else r = v[15:0];
    return r;
  endfunction

endpackage

// ===== rtl/fsp_mul.sv =====
// shared signed multiplier, registered operands and product
module fsp_mul (
  input  logic               clk,
  input  fsp_pkg::mop_t      a,
  input  fsp_pkg::mop_t      b,
  output fsp_pkg::wide_t     p
);

  fsp_pkg::mop_t  a_r;
  fsp_pkg::mop_t  b_r;
  fsp_pkg::wide_t p_r;

  always_ff @(posedge clk) begin
    a_r <= a;
    b_r <= b;
    p_r <= a_r * b_r;
  end

  assign p = p_r;

endmodule

// ===== rtl/fm_stereo_pilot_pll.sv =====
// fm stereo 19 khz pilot pll: one composite sample in, references, l-r and lock flags out.
// Each sample passes through accept, 24 sequencer steps and output load; every
// RENORM_PERIOD-th sample the oscillator renormalization adds 8 more steps.
// The pace is set by the single shared 36x36 multiplier, which registers its operands and
// then its product and does all 21 products a sample needs, 25 with renormalization. The
// block takes no sample while one is in work; a finished word waits in the output register.
module fm_stereo_pilot_pll #(
  parameter int RENORM_PERIOD = fsp_pkg::RENORM_PERIOD_DEF,
  parameter int PHASE_CYCLES  = fsp_pkg::PHASE_CYCLES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // sample
  input  logic        in_tlast,   // block_end
  output logic        out_tvalid,
  input  logic        out_tready,
  // stereo_ref, difference_out, rds_ref_cos, rds_ref_sin, bit_clock_phase
  output logic [79:0] out_tdata,
  output logic [1:0]  out_tuser,  // stereo_locked, pilot_tracked
  output logic        out_tlast,  // block_end_out
  input  logic        cfg_we,
  input  logic [3:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  localparam int PCW = (PHASE_CYCLES > 1) ? $clog2(PHASE_CYCLES) : 1;
  localparam int RCW = $clog2(RENORM_PERIOD);
  localparam logic [PCW:0]          PC_U = (PCW+1)'(PHASE_CYCLES);
  localparam logic signed [PCW+1:0] PC_S = (PCW+2)'(PHASE_CYCLES);

  typedef enum logic [5:0] {
    ST_IDLE, ST_S0, ST_S1, ST_S2, ST_S3, ST_S4, ST_S5, ST_S6, ST_S7, ST_S8, ST_S9,
    ST_S10, ST_S11, ST_S12, ST_S13, ST_S14, ST_S15, ST_S16, ST_S17, ST_S18, ST_S19,
    ST_S20, ST_S21, ST_S22, ST_S23, ST_S24, ST_S25, ST_S26, ST_S27, ST_S28, ST_S29,
    ST_S30, ST_S31, ST_FIN
  } state_t;

  state_t state_r;

  // configuration
  logic [31:0] phase_step_r, nom_rot_r, lock_thr_r, track_thr_r;
  logic [23:0] gain_prop_r, gain_int_r, lock_smooth_r, release_hold_r;

  // loop state
  logic signed [31:0] fi_r, osc_cos_r, osc_sin_r, ll_r;
  logic [31:0]        acc_r;
  logic [PCW-1:0]     pc_r;
  logic [RCW-1:0]     rn_r;
  logic               locked_r, tracked_r;
  logic [23:0]        rel_cnt_r;

  // per-sample working registers
  logic signed [15:0] x_r;
  logic               be_r;
  logic signed [31:0] c_r, s_r, tgt_r, d_r, sd_r, cd_r, stc_r, sts_r, g_r;
  logic signed [17:0] c16_r, s16_r;
  logic signed [35:0] err_r, tc_r, ts_r;
  logic signed [34:0] r30_r;
  logic signed [39:0] t1_r, t2_r;
  logic signed [15:0] o0_r, o1_r, o2_r, o3_r;
  logic [15:0]        dq_r;

  // output register
  logic        out_tvalid_r;
  logic [79:0] out_tdata_r;
  logic [1:0]  out_tuser_r;
  logic        out_tlast_r;

  fsp_pkg::mop_t  mul_a, mul_b;
  fsp_pkg::wide_t p;

  fsp_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(p));

  // phase accumulator and pilot cycle wrap
  fsp_pkg::wide_t          ph_sum;
  logic signed [2:0]       carry;
  logic signed [PCW+1:0]   pc_sum;
  logic [PCW-1:0]          pc_new;

  always_comb begin
    ph_sum = fsp_pkg::wide_t'({1'b0, acc_r}) + fsp_pkg::wide_t'({1'b0, phase_step_r})
           + fsp_pkg::rnd(p, 32);
    carry  = 3'(ph_sum >>> 32);
    pc_sum = $signed({2'b00, pc_r}) + (PCW+2)'(carry);
    if (pc_sum < 0) pc_sum = pc_sum + PC_S;
    else if (pc_sum >= PC_S) pc_sum = pc_sum - PC_S;
    pc_new = PCW'(pc_sum);
  end

  // bit clock: {pilot cycle, phase[31:16]} over the cycle count, exact reciprocal
  // multiply for any numerator below 2^22
  localparam int          BC_SH = 22 + PCW;
  localparam logic [44:0] BC_M  =
    45'(((64'd1 << BC_SH) + 64'(PHASE_CYCLES) - 64'd1) / 64'(PHASE_CYCLES));

  logic [21:0] bc_num;
  logic [44:0] bc_prod;
  assign bc_num  = 22'({pc_r, acc_r[31:16]});
  assign bc_prod = 45'(bc_num) * BC_M;

  logic signed [15:0] rot_c, rot_s;
  assign rot_c = nom_rot_r[31:16];
  assign rot_s = nom_rot_r[15:0];

  // multiplier operand select per step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_S0:  begin mul_a = fsp_pkg::mop_t'(x_r);   mul_b = fsp_pkg::mop_t'(s_r);   end
      ST_S1:  begin mul_a = fsp_pkg::mop_t'(x_r);   mul_b = fsp_pkg::mop_t'(c_r);   end
      ST_S2:  begin mul_a = fsp_pkg::mop_t'(c16_r); mul_b = fsp_pkg::mop_t'(c16_r); end
      ST_S3:  begin mul_a = fsp_pkg::mop_t'(s_r);   mul_b = fsp_pkg::mop_t'(c_r);   end
      ST_S4:  begin mul_a = fsp_pkg::mop_t'({1'b0, gain_int_r}); mul_b = err_r; end
      ST_S5:  begin mul_a = fsp_pkg::mop_t'(s16_r); mul_b = fsp_pkg::mop_t'(s16_r); end
      ST_S6:  begin mul_a = fsp_pkg::mop_t'({1'b0, gain_prop_r}); mul_b = err_r; end
      ST_S7:  begin mul_a = fsp_pkg::mop_t'(c16_r); mul_b = tc_r; end
      ST_S8:  begin
        mul_a = fsp_pkg::mop_t'({1'b0, lock_smooth_r});
        mul_b = fsp_pkg::mop_t'(fsp_pkg::wide_t'(tgt_r) - fsp_pkg::wide_t'(ll_r));
      end
      ST_S9:  begin mul_a = fsp_pkg::mop_t'(x_r);   mul_b = fsp_pkg::mop_t'(r30_r); end
      ST_S10: begin mul_a = fsp_pkg::mop_t'(d_r);   mul_b = fsp_pkg::INV_PI_Q32;    end
      ST_S11: begin mul_a = fsp_pkg::mop_t'(d_r);   mul_b = fsp_pkg::mop_t'(d_r);   end
      ST_S12: begin mul_a = fsp_pkg::mop_t'(s16_r); mul_b = ts_r; end
      ST_S13: begin mul_a = fsp_pkg::mop_t'(rot_s); mul_b = fsp_pkg::mop_t'(sd_r);  end
      ST_S14: begin mul_a = fsp_pkg::mop_t'(rot_c); mul_b = fsp_pkg::mop_t'(cd_r);  end
      ST_S15: begin mul_a = fsp_pkg::mop_t'(rot_c); mul_b = fsp_pkg::mop_t'(sd_r);  end
      ST_S16: begin mul_a = fsp_pkg::mop_t'(rot_s); mul_b = fsp_pkg::mop_t'(cd_r);  end
      ST_S18: begin mul_a = fsp_pkg::mop_t'(c_r);   mul_b = fsp_pkg::mop_t'(stc_r); end
      ST_S19: begin mul_a = fsp_pkg::mop_t'(s_r);   mul_b = fsp_pkg::mop_t'(stc_r); end
      ST_S20: begin mul_a = fsp_pkg::mop_t'(s_r);   mul_b = fsp_pkg::mop_t'(sts_r); end
      ST_S21: begin mul_a = fsp_pkg::mop_t'(c_r);   mul_b = fsp_pkg::mop_t'(sts_r); end
      ST_S24: begin
        mul_a = fsp_pkg::mop_t'(osc_cos_r); mul_b = fsp_pkg::mop_t'(osc_cos_r);
      end
      ST_S25: begin
        mul_a = fsp_pkg::mop_t'(osc_sin_r); mul_b = fsp_pkg::mop_t'(osc_sin_r);
      end
      ST_S28: begin mul_a = fsp_pkg::mop_t'(osc_cos_r); mul_b = fsp_pkg::mop_t'(g_r); end
      ST_S29: begin mul_a = fsp_pkg::mop_t'(osc_sin_r); mul_b = fsp_pkg::mop_t'(g_r); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // hysteresis levels, Q1.15 thresholds moved to the Q3.29 metric scale
  fsp_pkg::wide_t lock_eng, lock_rel, trk_eng, trk_rel, ll_w;
  assign lock_eng = fsp_pkg::wide_t'($signed(lock_thr_r[31:16])) <<< 14;
  assign lock_rel = fsp_pkg::wide_t'($signed(lock_thr_r[15:0])) <<< 14;
  assign trk_eng  = fsp_pkg::wide_t'($signed(track_thr_r[31:16])) <<< 14;
  assign trk_rel  = fsp_pkg::wide_t'($signed(track_thr_r[15:0])) <<< 14;
  assign ll_w     = fsp_pkg::wide_t'(ll_r);

  logic [24:0] rel_cnt_inc;
  assign rel_cnt_inc = {1'b0, rel_cnt_r} + 25'd1;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_step_r   <= fsp_pkg::PHASE_STEP_RST;
      nom_rot_r      <= fsp_pkg::NOM_ROT_RST;
      gain_prop_r    <= fsp_pkg::GAIN_PROP_RST;
      gain_int_r     <= fsp_pkg::GAIN_INT_RST;
      lock_smooth_r  <= fsp_pkg::LOCK_SMOOTH_RST;
      release_hold_r <= fsp_pkg::RELEASE_HOLD_RST;
      lock_thr_r     <= '0;
      track_thr_r    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        fsp_pkg::REG_PHASE_STEP:   phase_step_r   <= cfg_wdata;
        fsp_pkg::REG_NOM_ROT:      nom_rot_r      <= cfg_wdata;
        fsp_pkg::REG_GAIN_PROP:    gain_prop_r    <= cfg_wdata[23:0];
        fsp_pkg::REG_GAIN_INT:     gain_int_r     <= cfg_wdata[23:0];
        fsp_pkg::REG_LOCK_SMOOTH:  lock_smooth_r  <= cfg_wdata[23:0];
        fsp_pkg::REG_RELEASE_HOLD: release_hold_r <= cfg_wdata[23:0];
        fsp_pkg::REG_LOCK_THR:     lock_thr_r     <= cfg_wdata;
        fsp_pkg::REG_TRACK_THR:    track_thr_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // sequencer: step k loads operands, step k+2 takes the product
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      fi_r         <= '0;
      acc_r        <= '0;
      pc_r         <= '0;
      osc_cos_r    <= 32'sh40000000;
      osc_sin_r    <= '0;
      rn_r         <= '0;
      ll_r         <= '0;
      locked_r     <= 1'b0;
      tracked_r    <= 1'b0;
      rel_cnt_r    <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (out_tvalid_r && out_tready && (state_r != ST_FIN)) out_tvalid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (in_tvalid) begin
            x_r     <= $signed(in_tdata);
            be_r    <= in_tlast;
            c_r     <= osc_cos_r;
            s_r     <= osc_sin_r;
            c16_r   <= 18'(fsp_pkg::rnd(fsp_pkg::wide_t'(osc_cos_r), 15));
            s16_r   <= 18'(fsp_pkg::rnd(fsp_pkg::wide_t'(osc_sin_r), 15));
            state_r <= ST_S0;
          end
        end
        ST_S0: state_r <= ST_S1;
        ST_S1: state_r <= ST_S2;
        ST_S2: begin
          err_r   <= 36'(fsp_pkg::rnd(-p, 14));
          state_r <= ST_S3;
        end
        ST_S3: begin
          tgt_r   <= fsp_pkg::sat32(fsp_pkg::rnd(p, 15));
          state_r <= ST_S4;
        end
        ST_S4: begin
          tc_r    <= 36'((p <<< 2) - fsp_pkg::THREE_Q30);
          state_r <= ST_S5;
        end
        ST_S5: begin
          o0_r    <= fsp_pkg::sat16(fsp_pkg::rnd(-p, 44));
          r30_r   <= 35'(fsp_pkg::rnd(-p, 29));
          state_r <= ST_S6;
        end
        ST_S6: begin
          fi_r    <= fsp_pkg::sat32(fsp_pkg::wide_t'(fi_r) + fsp_pkg::rnd(p, 32));
          state_r <= ST_S7;
        end
        ST_S7: begin
          ts_r    <= 36'(fsp_pkg::THREE_Q30 - (p <<< 2));
          state_r <= ST_S8;
        end
        ST_S8: begin
          d_r     <= fsp_pkg::sat32(fsp_pkg::wide_t'(fi_r) + fsp_pkg::rnd(p, 24));
          state_r <= ST_S9;
        end
        ST_S9: begin
          o2_r    <= fsp_pkg::sat16(fsp_pkg::rnd(p, 30));
          sd_r    <= 32'(fsp_pkg::rnd(fsp_pkg::wide_t'(d_r), 1));
          state_r <= ST_S10;
        end
        ST_S10: begin
          ll_r    <= fsp_pkg::sat32(fsp_pkg::wide_t'(ll_r) + fsp_pkg::rnd(p, 32));
          state_r <= ST_S11;
        end
        ST_S11: begin
          o1_r <= fsp_pkg::sat16(fsp_pkg::rnd(p, 29));
          if (!locked_r && ll_w > lock_eng) begin
            locked_r  <= 1'b1;
            rel_cnt_r <= '0;
          end else if (locked_r) begin
            if (ll_w < lock_rel) begin
              if (rel_cnt_inc >= {1'b0, release_hold_r}) begin
                locked_r  <= 1'b0;
                rel_cnt_r <= '0;
              end else begin
                rel_cnt_r <= rel_cnt_inc[23:0];
              end
            end else begin
              rel_cnt_r <= '0;
            end
          end
          if (!tracked_r && ll_w > trk_eng) tracked_r <= 1'b1;
          else if (tracked_r && ll_w < trk_rel) tracked_r <= 1'b0;
          state_r <= ST_S12;
        end
        ST_S12: begin
          acc_r   <= ph_sum[31:0];
          pc_r    <= pc_new;
          state_r <= ST_S13;
        end
        ST_S13: begin
          cd_r    <= 32'(fsp_pkg::ONE_Q30 - fsp_pkg::rnd(p, 33));
          dq_r    <= bc_prod[BC_SH +: 16];
          state_r <= ST_S14;
        end
        ST_S14: begin
          o3_r    <= fsp_pkg::sat16(fsp_pkg::rnd(p, 30));
          state_r <= ST_S15;
        end
        ST_S15: begin
          t1_r    <= 40'(fsp_pkg::rnd(p, 15));
          state_r <= ST_S16;
        end
        ST_S16: begin
          t2_r    <= 40'(fsp_pkg::rnd(p, 15));
          state_r <= ST_S17;
        end
        ST_S17: begin
          stc_r   <= fsp_pkg::sat32(fsp_pkg::wide_t'(t2_r) - fsp_pkg::wide_t'(t1_r));
          t1_r    <= 40'(fsp_pkg::rnd(p, 15));
          state_r <= ST_S18;
        end
        ST_S18: begin
          sts_r   <= fsp_pkg::sat32(fsp_pkg::rnd(p, 15) + fsp_pkg::wide_t'(t1_r));
          state_r <= ST_S19;
        end
        ST_S19: state_r <= ST_S20;
        ST_S20: begin
          t1_r    <= 40'(fsp_pkg::rnd(p, 30));
          state_r <= ST_S21;
        end
        ST_S21: begin
          t2_r    <= 40'(fsp_pkg::rnd(p, 30));
          state_r <= ST_S22;
        end
        ST_S22: begin
          osc_cos_r <= fsp_pkg::sat32(fsp_pkg::wide_t'(t1_r) - fsp_pkg::rnd(p, 30));
          state_r   <= ST_S23;
        end
        ST_S23: begin
          osc_sin_r <= fsp_pkg::sat32(fsp_pkg::wide_t'(t2_r) + fsp_pkg::rnd(p, 30));
          if (rn_r == RCW'(RENORM_PERIOD - 1)) begin
            rn_r    <= '0;
            state_r <= ST_S24;
          end else begin
            rn_r    <= rn_r + 1'b1;
            state_r <= ST_FIN;
          end
        end
        ST_S24: state_r <= ST_S25;
        ST_S25: state_r <= ST_S26;
        ST_S26: begin
          t1_r    <= 40'(fsp_pkg::rnd(p, 30));
          state_r <= ST_S27;
        end
        ST_S27: begin
          // newton step g = 1.5 - |osc|^2 / 2
          g_r     <= fsp_pkg::sat32(fsp_pkg::ONE_HALF_Q30
                     - fsp_pkg::rnd(fsp_pkg::wide_t'(t1_r) + fsp_pkg::rnd(p, 30), 1));
          state_r <= ST_S28;
        end
        ST_S28: state_r <= ST_S29;
        ST_S29: state_r <= ST_S30;
        ST_S30: begin
          osc_cos_r <= fsp_pkg::sat32(fsp_pkg::rnd(p, 30));
          state_r   <= ST_S31;
        end
        ST_S31: begin
          osc_sin_r <= fsp_pkg::sat32(fsp_pkg::rnd(p, 30));
          state_r   <= ST_FIN;
        end
        ST_FIN: begin
          if (!out_tvalid_r || out_tready) begin
            out_tvalid_r <= 1'b1;
            out_tdata_r  <= {dq_r, o3_r, o2_r, o1_r, o0_r};
            out_tuser_r  <= {tracked_r, locked_r};
            out_tlast_r  <= be_r;
            state_r      <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;
  assign out_tlast  = out_tlast_r;

`include "fm_stereo_pilot_pll_defines.svh"

  `FSP_ASSERT_NXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready)
  `FSP_ASSERT_NXT(a_fin_loads_word, (state_r == ST_FIN) && (!out_tvalid_r || out_tready),
                  out_tvalid_r && in_tready)
  `FSP_ASSERT_IMP(a_pilot_cycle_range, 1'b1, {1'b0, pc_r} < PC_U)

endmodule

// ===== tb/fm_stereo_pilot_pll_tb.sv =====
// self-checking testbench for the fm stereo pilot pll, with a cycle-free bit-true predictor
`timescale 1ns / 100ps

module fm_stereo_pilot_pll_tb;

  localparam logic [3:0] REG_SPARE_LO = 4'd8;
  localparam logic [3:0] REG_SPARE_HI = 4'd15;
  localparam longint ONE_Q30_L   = 64'sd1073741824;
  localparam longint HALF3_Q30_L = 64'sd1610612736;
  localparam longint THREE_Q30_L = 64'sd3221225472;
  localparam longint INV_PI_L    = 64'sd1367130551;
  localparam int WATCHDOG_LIMIT = 4000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [79:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_we = 1'b0;
  logic [3:0]  cfg_index = '0;
  logic [31:0] cfg_wdata = '0;

  fm_stereo_pilot_pll DUT (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  typedef struct {
    logic [15:0] smp;
    logic        blk_end;
  } sample_word_t;

  typedef struct {
    logic [15:0] stereo_ref;
    logic [15:0] diff;
    logic [15:0] rds_cos;
    logic [15:0] rds_sin;
    logic [15:0] bit_clk;
    logic        locked;
    logic        tracked;
    logic        blk_end;
  } pll_word_t;

  sample_word_t pending_samples[$];
  pll_word_t    expected_words[$];
  int  mismatch_count = 0;
  int  samples_in = 0;
  bit  took = 1'b0;
  bit  no_idle = 1'b0;
  int  src_gap = 0, sink_gap = 0, hold_cnt = 0;
  bit  hold_done = 1'b0;
  int  quiet_cycles = 0;

  // predictor registers and state
  logic [31:0] p_step, nom_rot, lock_thr, track_thr;
  logic [23:0] g_prop, g_int, l_smooth, rel_hold, rel_cnt;
  logic signed [31:0] freq_int, osc_c, osc_s, lock_lvl;
  logic [31:0] ph_acc;
  logic [3:0]  pil_cyc;
  int          renorm_cnt;
  bit          lock_f, track_f;

  function automatic longint rd(longint v, int n);
    return (v + (longint'(1) <<< (n - 1))) >>> n;
  endfunction

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic logic [15:0] clip16(longint v);
    if (v > 64'sd32767) return 16'h7fff;
    if (v < -64'sd32768) return 16'h8000;
    return v[15:0];
  endfunction

  task automatic pll_reset_state();
    p_step = fsp_pkg::PHASE_STEP_RST; nom_rot = fsp_pkg::NOM_ROT_RST;
    g_prop = fsp_pkg::GAIN_PROP_RST; g_int = fsp_pkg::GAIN_INT_RST;
    l_smooth = fsp_pkg::LOCK_SMOOTH_RST; rel_hold = fsp_pkg::RELEASE_HOLD_RST;
    lock_thr = '0; track_thr = '0;
    freq_int = '0; ph_acc = '0; pil_cyc = '0; osc_c = 32'sh40000000; osc_s = '0;
    renorm_cnt = 0; lock_lvl = '0; lock_f = 1'b0; track_f = 1'b0; rel_cnt = '0;
  endtask

  task automatic pll_write_reg(logic [3:0] idx, logic [31:0] val);
    case (idx)
      fsp_pkg::REG_PHASE_STEP:   p_step = val;
      fsp_pkg::REG_NOM_ROT:      nom_rot = val;
      fsp_pkg::REG_GAIN_PROP:    g_prop = val[23:0];
      fsp_pkg::REG_GAIN_INT:     g_int = val[23:0];
      fsp_pkg::REG_LOCK_SMOOTH:  l_smooth = val[23:0];
      fsp_pkg::REG_RELEASE_HOLD: rel_hold = val[23:0];
      fsp_pkg::REG_LOCK_THR:     lock_thr = val;
      fsp_pkg::REG_TRACK_THR:    track_thr = val;
      default: ;
    endcase
  endtask

  task automatic pll_predict(sample_word_t w);
    longint x, c, s, err, dv, sum, carry, rc, rs, sd, cd, stc, sts, nc, ns, g;
    longint tgt, eng, rel, r30, c16, s16;
    logic [35:0] full_ph;
    pll_word_t e;
    x = longint'($signed(w.smp));
    c = longint'(osc_c);
    s = longint'(osc_s);
    // phase detector and pi loop filter
    err = rd(-(x * s), 14);
    freq_int = 32'(clip32(longint'(freq_int) + rd(longint'(g_int) * err, 32)));
    dv = clip32(longint'(freq_int) + rd(longint'(g_prop) * err, 24));
    sum = longint'(ph_acc) + longint'(p_step) + rd(dv * INV_PI_L, 32);
    carry = sum >>> 32;
    ph_acc = sum[31:0];
    pil_cyc = pil_cyc + carry[3:0];
    // rotator update with small-angle correction
    rc = longint'($signed(nom_rot[31:16]));
    rs = longint'($signed(nom_rot[15:0]));
    sd = rd(dv, 1);
    cd = ONE_Q30_L - rd(dv * dv, 33);
    stc = clip32(rd(rc * cd, 15) - rd(rs * sd, 15));
    sts = clip32(rd(rs * cd, 15) + rd(rc * sd, 15));
    nc = clip32(rd(c * stc, 30) - rd(s * sts, 30));
    ns = clip32(rd(s * stc, 30) + rd(c * sts, 30));
    renorm_cnt++;
    if (renorm_cnt >= fsp_pkg::RENORM_PERIOD_DEF) begin
      renorm_cnt = 0;
      g = clip32(HALF3_Q30_L - rd(rd(nc * nc, 30) + rd(ns * ns, 30), 1));
      nc = clip32(rd(nc * g, 30));
      ns = clip32(rd(ns * g, 30));
    end
    osc_c = nc[31:0];
    osc_s = ns[31:0];
    // lock metric with hysteresis and release hold
    tgt = clip32(rd(x * c, 15));
    lock_lvl = 32'(clip32(longint'(lock_lvl)
                      + rd(longint'(l_smooth) * (tgt - longint'(lock_lvl)), 32)));
    eng = longint'($signed(lock_thr[31:16])) * 16384;
    rel = longint'($signed(lock_thr[15:0])) * 16384;
    if (!lock_f && longint'(lock_lvl) > eng) begin
      lock_f = 1'b1;
      rel_cnt = '0;
    end else if (lock_f) begin
      if (longint'(lock_lvl) < rel) begin
        rel_cnt++;
        if (rel_cnt >= rel_hold) begin
          lock_f = 1'b0;
          rel_cnt = '0;
        end
      end else begin
        rel_cnt = '0;
      end
    end
    eng = longint'($signed(track_thr[31:16])) * 16384;
    rel = longint'($signed(track_thr[15:0])) * 16384;
    if (!track_f && longint'(lock_lvl) > eng) track_f = 1'b1;
    else if (track_f && longint'(lock_lvl) < rel) track_f = 1'b0;
    // references use the oscillator from before the update
    r30 = rd(-(s * c), 29);
    c16 = rd(c, 15);
    s16 = rd(s, 15);
    full_ph = {pil_cyc, ph_acc};
    e.stereo_ref = clip16(rd(-(s * c), 44));
    e.diff = clip16(rd(x * r30, 29));
    e.rds_cos = clip16(rd(c16 * (4 * c16 * c16 - THREE_Q30_L), 30));
    e.rds_sin = clip16(rd(s16 * (THREE_Q30_L - 4 * s16 * s16), 30));
    e.bit_clk = full_ph[35:20];
    e.locked = lock_f;
    e.tracked = track_f;
    e.blk_end = w.blk_end;
    expected_words.push_back(e);
  endtask

  task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
      mismatch_count++;
    end
  endtask

  // monitor: register writes, accepted samples and accepted result words
  always @(posedge clk) begin
    pll_word_t e;
    if (rst_n) begin
      took <= in_tvalid && in_tready;
      if (cfg_we) pll_write_reg(cfg_index, cfg_wdata);
      if (in_tvalid && in_tready) begin
        pll_predict('{smp: in_tdata, blk_end: in_tlast});
        samples_in++;
      end
      if (out_tvalid && out_tready) begin
        if (expected_words.size() == 0) begin
          $error("result word with nothing expected");
          mismatch_count++;
        end else begin
          e = expected_words.pop_front();
          check_field("stereo_ref", e.stereo_ref, out_tdata[15:0]);
          check_field("difference_out", e.diff, out_tdata[31:16]);
          check_field("rds_ref_cos", e.rds_cos, out_tdata[47:32]);
          check_field("rds_ref_sin", e.rds_sin, out_tdata[63:48]);
          check_field("bit_clock_phase", e.bit_clk, out_tdata[79:64]);
          check_field("stereo_locked", e.locked, out_tuser[0]);
          check_field("pilot_tracked", e.tracked, out_tuser[1]);
          check_field("block_end_out", e.blk_end, out_tlast);
        end
      end
    end
  end

  // sample driver
  always @(negedge clk) begin
    logic v;
    sample_word_t w;
    v = in_tvalid && !took;
    if (rst_n && !v) begin
      if (src_gap > 0) begin
        src_gap--;
      end else if (pending_samples.size() > 0) begin
        if (!no_idle && $urandom_range(0, 9) == 0) begin
          src_gap = $urandom_range(0, 10);
        end else begin
          w = pending_samples.pop_front();
          in_tdata <= w.smp;
          in_tlast <= w.blk_end;
          v = 1'b1;
        end
      end
    end
    in_tvalid <= v;
  end

  // result sink, with one long hold-off so the block backs up its input
  always @(negedge clk) begin
    logic r;
    r = 1'b1;
    if (!hold_done && samples_in >= 300) begin
      hold_done = 1'b1;
      hold_cnt = 400;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      r = 1'b0;
    end else if (sink_gap > 0) begin
      sink_gap--;
      r = 1'b0;
    end else if (!no_idle && $urandom_range(0, 9) == 0) begin
      sink_gap = $urandom_range(0, 10);
      r = 1'b0;
    end
    out_tready <= rst_n && r;
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic write_reg(logic [3:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_idle();
    wait (pending_samples.size() == 0 && expected_words.size() == 0 && !in_tvalid);
    repeat (60) @(negedge clk);
  endtask

  task automatic push_sample(int v, bit be);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    pending_samples.push_back('{smp: v[15:0], blk_end: be});
  endtask

  task automatic write_all(logic [31:0] st, logic [31:0] rot, logic [31:0] gp,
                           logic [31:0] gi, logic [31:0] ls, logic [31:0] rh,
                           logic [31:0] lt, logic [31:0] tt);
    write_reg(fsp_pkg::REG_PHASE_STEP, st);
    write_reg(fsp_pkg::REG_NOM_ROT, rot);
    write_reg(fsp_pkg::REG_GAIN_PROP, gp);
    write_reg(fsp_pkg::REG_GAIN_INT, gi);
    write_reg(fsp_pkg::REG_LOCK_SMOOTH, ls);
    write_reg(fsp_pkg::REG_RELEASE_HOLD, rh);
    write_reg(fsp_pkg::REG_LOCK_THR, lt);
    write_reg(fsp_pkg::REG_TRACK_THR, tt);
  endtask

  // mostly pilot-like composite with random amplitude, noise and dropouts
  task automatic push_composite(int n);
    real ph, amp, cyc;
    int k, burst;
    ph = 0.0;
    cyc = 0.0791643 * (0.98 + 0.04 * $urandom_range(0, 1000) / 1000.0);
    amp = 2000.0 + $urandom_range(0, 14000);
    burst = 0;
    for (k = 0; k < n; k++) begin
      if (burst > 0) begin
        burst--;
        push_sample($signed(16'($urandom)), $urandom_range(0, 15) == 0);
      end else begin
        if ($urandom_range(0, 60) == 0) begin
          burst = $urandom_range(1, 20);
          amp = $urandom_range(0, 20000);
        end
        push_sample(int'(amp * $cos(ph) + 6000.0 * $sin(2.0 * ph) * $sin(0.01 * k)
                         + $urandom_range(0, 4000) - 2000), $urandom_range(0, 15) == 0);
      end
      ph = ph + 6.283185307 * cyc;
    end
  endtask

  initial begin
    int p;
    pll_reset_state();
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // directed: field extremes and block end markers
    push_sample(32767, 1'b0); push_sample(-32768, 1'b1); push_sample(0, 1'b0);
    push_sample(-1, 1'b1); push_sample(1, 1'b0); push_sample(32767, 1'b1);
    push_sample(32767, 1'b0); push_sample(-32768, 1'b0); push_sample(-32768, 1'b0);
    push_sample(16384, 1'b1); push_sample(-16384, 1'b0);
    push_composite(10);
    wait_idle();

    // all zero, with zero release hold and ignored spare indexes
    write_all('0, '0, '0, '0, '0, '0, '0, '0);
    write_reg(REG_SPARE_LO, '1);
    write_reg(REG_SPARE_HI, 32'h1234_5678);
    for (p = 0; p < 150; p++) push_sample($signed(16'($urandom)), $urandom_range(0, 1));
    wait_idle();

    // all ones
    write_all('1, '1, '1, '1, '1, '1, '1, '1);
    for (p = 0; p < 150; p++) push_sample($signed(16'($urandom)), $urandom_range(0, 1));
    wait_idle();

    // nominal loop with a short release hold, where lock comes and goes
    write_all(fsp_pkg::PHASE_STEP_RST, fsp_pkg::NOM_ROT_RST, 32'd2000000, 32'd800000,
              32'd8000000, 32'd3, 32'h0800_0400, 32'h0400_0200);
    push_composite(200);
    wait_idle();

    // crossed thresholds, zero hold, large steps so the phase carry goes both ways
    write_all(32'hF000_0000, 32'h5A82_5A82, 32'hFF_FFFF, 32'h00_FFFF, 32'h80_0000,
              32'd0, 32'h0100_0800, 32'hF000_1000);
    push_composite(150);
    wait_idle();

    for (p = 0; p < 4; p++) begin
      if (p == 3) no_idle = 1'b1;
      write_all(($urandom_range(0, 1) ? fsp_pkg::PHASE_STEP_RST + $urandom_range(0, 9999999)
                                      : $urandom),
                ($urandom_range(0, 1) ? 32'(fsp_pkg::NOM_ROT_RST) : $urandom),
                $urandom_range(0, 16777215), $urandom_range(0, 4000000),
                $urandom_range(0, 16777215), $urandom_range(0, 40),
                {16'($urandom_range(0, 9000)), 16'($urandom_range(0, 5000))},
                $urandom);
      push_composite(170);
      wait_idle();
    end

    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/fsp_pkg.sv
rtl/fsp_mul.sv
rtl/fm_stereo_pilot_pll.sv
tb/fm_stereo_pilot_pll_tb.sv
